@@ design/dcac_pkg.sv @@
// ----------------------------------------------------------------------------
// dcac_pkg: shared types and constants of the airtime credit block
// Operation and mode codes, register map, datapath widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dcac_pkg;

    // Operation codes carried on s_tuser.
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_SEND    = 2'd1,
        OP_PROMOTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Radio modes.
    typedef enum logic [1:0] {
        MODE_OFFLINE   = 2'd0,
        MODE_END_NODE  = 2'd1,
        MODE_GATEWAY   = 2'd2,
        MODE_SUSPENDED = 2'd3
    } mode_t;

    // Register indexes (byte address is four times the index).
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned REG_IX_W = 3;
    localparam logic [REG_IX_W-1:0] REG_SF       = 3'd0;
    localparam logic [REG_IX_W-1:0] REG_PREAMBLE = 3'd1;
    localparam logic [REG_IX_W-1:0] REG_CR       = 3'd2;
    localparam logic [REG_IX_W-1:0] REG_CRC      = 3'd3;
    localparam logic [REG_IX_W-1:0] REG_IMPLICIT = 3'd4;

    // Register reset values.
    localparam logic [3:0]  SF_RESET       = 4'd7;
    localparam logic [15:0] PREAMBLE_RESET = 16'd10;
    localparam logic [3:0]  CR_RESET       = 4'd5;
    localparam logic        CRC_RESET      = 1'b1;
    localparam logic        IMPLICIT_RESET = 1'b0;

    // Datapath widths.
    localparam int unsigned NUM_W    = 21;  // signed symbol-count numerator
    localparam int unsigned DVD_W    = 20;  // numerator magnitude, quotient
    localparam int unsigned DVS_W    = 6;   // 4*sf
    localparam int unsigned MPLR_W   = 4;   // coding denominator
    localparam int unsigned PROD_W   = DVD_W + MPLR_W;
    localparam int unsigned SYM_W    = 28;  // signed symbol count times four
    localparam int unsigned AIR_W    = 42;  // time on air before reporting
    localparam int unsigned TEN_W    = 36;  // ten times the elapsed ms
    localparam int unsigned DELTA_W  = 44;  // signed credit change
    localparam int unsigned OUT_CR_W = 40;  // reported credit width

    localparam logic signed [31:0] GATE_FLOOR_US = -32'sd1000000;

endpackage : dcac_pkg

`default_nettype wire

@@ design/dcac_div.sv @@
// ----------------------------------------------------------------------------
// dcac_div: bit-serial restoring divider
// Produces one quotient bit per cycle of an unsigned dividend by a small divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dcac_div (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire  [dcac_pkg::DVD_W-1:0]    dividend,
    input  wire  [dcac_pkg::DVS_W-1:0]    divisor,
    output logic                          done,
    output logic [dcac_pkg::DVD_W-1:0]    quotient
);

    localparam int unsigned CNT_W = $clog2(dcac_pkg::DVD_W);

    logic [dcac_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [dcac_pkg::DVS_W-1:0] dvs_reg;
    logic [dcac_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [dcac_pkg::DVS_W:0]   trial;
    logic                       fits;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        trial    = {rem_reg, dvd_reg[dcac_pkg::DVD_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? dcac_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                        : dcac_pkg::DVS_W'(trial);
        dvd_next = {dvd_reg[dcac_pkg::DVD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(dcac_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule : dcac_div

`default_nettype wire

@@ design/dcac_mul.sv @@
// ----------------------------------------------------------------------------
// dcac_mul: bit-serial shift-add multiplier
// Multiplies the quotient by the coding denominator, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcac_mul (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire  [dcac_pkg::DVD_W-1:0]    multiplicand,
    input  wire  [dcac_pkg::MPLR_W-1:0]   multiplier,
    output logic                          done,
    output logic [dcac_pkg::PROD_W-1:0]   product
);

    localparam int unsigned CNT_W = $clog2(dcac_pkg::MPLR_W);

    logic [dcac_pkg::PROD_W-1:0] mc_reg;
    logic [dcac_pkg::PROD_W-1:0] acc_reg;
    logic [dcac_pkg::MPLR_W-1:0] mp_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(dcac_pkg::MPLR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mc_reg  <= dcac_pkg::PROD_W'(multiplicand);
            mp_reg  <= multiplier;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= {mc_reg[dcac_pkg::PROD_W-2:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[dcac_pkg::MPLR_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule : dcac_mul

`default_nettype wire

@@ design/duty_cycle_airtime_credit_top.sv @@
// ----------------------------------------------------------------------------
// duty_cycle_airtime_credit_top: radio transmit-time credit and mode keeper
// Charges packet time on air against a credit that earns 1% of elapsed time.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Ports                         Contents
// s_       in         s_tvalid/s_tready/s_tdata     now_ms, payload_length, radio_ok
//                     s_tuser                       operation
// m_       out        m_tvalid/m_tready/m_tdata     granted, mode, credit_us,
//                                                   airtime_us, credit_negative,
//                                                   too_long
// apb      in/out     psel/penable/pwrite/paddr/... five configuration registers
//
// An item that charges the credit passes these steps after acceptance: the
// numerator of the symbol count goes through a 20-step restoring divider,
// one quotient bit per cycle; the quotient is handed on to a 4-step
// shift-add multiply, and the product is registered; then the shift by the
// spreading factor, the credit change, the saturating add and the result
// each have a state of their own. The next item is taken only once the
// result is written. Other items go from acceptance straight to the result
// state. Reset is synchronous and active low; it sets the registers to their
// defaults, the mode to offline and the credit to zero.
// A stalled result stays in the output register while the next item is taken;
// only the final write of that next item waits for the register to free up.
//
`default_nettype none

module duty_cycle_airtime_credit_top #(
    parameter int unsigned MAX_PAYLOAD = 256,
    parameter int unsigned CREDIT_BITS = 40
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Input channel.
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [55:0]                  s_tdata,  // now_ms[31:0], payload_length[47:32],
                                                   // radio_ok[48], zero fill [55:49]
    input  wire  [1:0]                   s_tuser,  // operation[1:0]
    // Result channel.
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [79:0]                  m_tdata,  // granted[0], mode[2:1],
                                                   // credit_us[42:3], airtime_us[74:43],
                                                   // credit_negative[75], too_long[76],
                                                   // zero fill [79:77]
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dcac_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Widths that follow from the credit width.
    localparam int unsigned SUM_W =
        ((CREDIT_BITS > dcac_pkg::DELTA_W) ? CREDIT_BITS : dcac_pkg::DELTA_W) + 1;
    localparam int unsigned CW =
        (CREDIT_BITS > dcac_pkg::OUT_CR_W) ? CREDIT_BITS : dcac_pkg::OUT_CR_W;

    localparam logic signed [SUM_W-1:0] CR_HI =
        {{(SUM_W-CREDIT_BITS+1){1'b0}}, {(CREDIT_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] CR_LO = ~CR_HI;
    localparam logic signed [CW-1:0] OUT_HI =
        {{(CW-dcac_pkg::OUT_CR_W+1){1'b0}}, {(dcac_pkg::OUT_CR_W-1){1'b1}}};
    localparam logic signed [CW-1:0] OUT_LO = ~OUT_HI;
    localparam logic signed [CREDIT_BITS-1:0] FLOOR =
        CREDIT_BITS'(dcac_pkg::GATE_FLOOR_US);

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_AIR  = 7'b0001000,
        ST_DLT  = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [3:0]  sf_reg;
    logic [15:0] pre_reg;
    logic [3:0]  cr_reg;
    logic        crc_reg;
    logic        imp_reg;

    // Block state.
    dcac_pkg::mode_t                 mode_reg;
    logic signed [CREDIT_BITS-1:0]   credit_reg;
    logic [31:0]                     last_reg;

    // Item registers.
    dcac_pkg::op_t                   op_reg;
    logic [31:0]                     now_reg;
    logic                            ok_reg;
    logic                            len_ok_reg;
    logic                            charge_reg;
    logic                            qneg_reg;
    logic                            dzero_reg;
    logic [dcac_pkg::PROD_W-1:0]     prod_reg;
    logic [dcac_pkg::AIR_W-1:0]      air_reg;
    logic [dcac_pkg::TEN_W-1:0]      ten_reg;
    logic signed [dcac_pkg::DELTA_W-1:0] delta_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;

    // Input fields.
    logic [31:0]       in_now;
    logic [15:0]       in_len;
    logic              in_ok;
    dcac_pkg::op_t     in_op;
    logic              accept;

    assign in_now = s_tdata[31:0];
    assign in_len = s_tdata[47:32];
    assign in_ok  = s_tdata[48];
    assign in_op  = dcac_pkg::op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Decide at acceptance whether the item charges and for which length.
    logic        len_ok;
    logic        charge_now;
    logic [15:0] charge_len;

    always_comb begin
        len_ok     = ({16'b0, in_len} <= 32'(MAX_PAYLOAD));
        charge_now = 1'b0;
        charge_len = in_len;
        case (in_op)
            dcac_pkg::OP_SEND: begin
                charge_now = len_ok;
            end
            dcac_pkg::OP_PROMOTE: begin
                charge_now = (mode_reg == dcac_pkg::MODE_SUSPENDED);
                charge_len = '0;
            end
            default: begin
                charge_now = 1'b0;
            end
        endcase
    end

    // Numerator of the payload symbol count: 8*len - 4*sf + 28 + 16*crc - 20*implicit.
    logic signed [dcac_pkg::NUM_W-1:0] num;
    logic [dcac_pkg::DVD_W-1:0]        num_mag;
    logic [dcac_pkg::DVS_W-1:0]        den;

    always_comb begin
        num = $signed(dcac_pkg::NUM_W'({charge_len, 3'b000}))
            + $signed(dcac_pkg::NUM_W'(28))
            + $signed(dcac_pkg::NUM_W'(crc_reg ? 16 : 0))
            - $signed(dcac_pkg::NUM_W'({sf_reg, 2'b00}))
            - $signed(dcac_pkg::NUM_W'(imp_reg ? 20 : 0));
        num_mag = num[dcac_pkg::NUM_W-1] ? dcac_pkg::DVD_W'(-num)
                                         : dcac_pkg::DVD_W'(num);
        den = {sf_reg, 2'b00};
    end

    // Serial divider and multiplier.
    logic                          div_done;
    logic [dcac_pkg::DVD_W-1:0]    div_q;
    logic                          mul_done;
    logic [dcac_pkg::PROD_W-1:0]   mul_p;
    logic [dcac_pkg::DVD_W-1:0]    q_masked;

    // A zero divisor yields a zero quotient.
    assign q_masked = dzero_reg ? '0 : div_q;

    dcac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && charge_now),
        .dividend (num_mag),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    dcac_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_done),
        .multiplicand (q_masked),
        .multiplier   (cr_reg),
        .done         (mul_done),
        .product      (mul_p)
    );

    // Symbol count times four, clamped at zero, then scaled by 2^sf.
    logic signed [dcac_pkg::SYM_W-1:0] sym_base;
    logic signed [dcac_pkg::SYM_W-1:0] sym_fix;
    logic signed [dcac_pkg::SYM_W-1:0] sym;
    logic [dcac_pkg::SYM_W-2:0]        sym_pos;
    logic [31:0]                       elapsed;

    always_comb begin
        sym_base = $signed(dcac_pkg::SYM_W'({pre_reg, 2'b00}))
                 + $signed(dcac_pkg::SYM_W'(49))
                 + $signed(dcac_pkg::SYM_W'({cr_reg, 2'b00}));
        sym_fix  = $signed(dcac_pkg::SYM_W'({prod_reg, 2'b00}));
        sym      = qneg_reg ? (sym_base - sym_fix) : (sym_base + sym_fix);
        sym_pos  = sym[dcac_pkg::SYM_W-1] ? '0 : sym[dcac_pkg::SYM_W-2:0];
        elapsed  = now_reg - last_reg;
    end

    // Saturating credit update.
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_sat;

    always_comb begin
        sum = SUM_W'(credit_reg) + SUM_W'(delta_reg);
        if (sum > CR_HI) begin
            sum_sat = CR_HI;
        end else if (sum < CR_LO) begin
            sum_sat = CR_LO;
        end else begin
            sum_sat = sum;
        end
    end

    // Result of the item, formed from the updated state.
    logic                              fin_granted;
    dcac_pkg::mode_t                   fin_mode;
    logic                              fin_too_long;
    logic [31:0]                       fin_air;
    logic                              fin_neg;
    logic signed [CW-1:0]              cr_wide;
    logic signed [CW-1:0]              cr_shown;

    always_comb begin
        fin_granted  = 1'b0;
        fin_mode     = mode_reg;
        fin_too_long = 1'b0;
        case (op_reg)
            dcac_pkg::OP_INIT: begin
                fin_granted = ok_reg;
                fin_mode    = ok_reg ? dcac_pkg::MODE_END_NODE : dcac_pkg::MODE_OFFLINE;
            end
            dcac_pkg::OP_SEND: begin
                fin_granted  = len_ok_reg;
                fin_too_long = !len_ok_reg;
            end
            dcac_pkg::OP_PROMOTE: begin
                case (mode_reg)
                    dcac_pkg::MODE_SUSPENDED: begin
                        if (credit_reg > 0) begin
                            fin_mode    = dcac_pkg::MODE_GATEWAY;
                            fin_granted = 1'b1;
                        end
                    end
                    dcac_pkg::MODE_GATEWAY: begin
                        if (credit_reg < FLOOR) begin
                            fin_mode = dcac_pkg::MODE_SUSPENDED;
                        end else begin
                            fin_granted = 1'b1;
                        end
                    end
                    dcac_pkg::MODE_OFFLINE: begin
                        if (ok_reg) begin
                            fin_mode    = dcac_pkg::MODE_GATEWAY;
                            fin_granted = 1'b1;
                        end
                    end
                    default: begin
                        fin_granted = 1'b0;
                    end
                endcase
            end
            default: begin
                fin_granted = 1'b0;
            end
        endcase

        // Reported airtime saturates at 32 bits; it is zero when nothing was charged.
        if (!charge_reg) begin
            fin_air = '0;
        end else if (|air_reg[dcac_pkg::AIR_W-1:32]) begin
            fin_air = '1;
        end else begin
            fin_air = air_reg[31:0];
        end
        fin_neg = charge_reg && credit_reg[CREDIT_BITS-1];

        cr_wide = CW'(credit_reg);
        if (cr_wide > OUT_HI) begin
            cr_shown = OUT_HI;
        end else if (cr_wide < OUT_LO) begin
            cr_shown = OUT_LO;
        end else begin
            cr_shown = cr_wide;
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= dcac_pkg::MODE_OFFLINE;
            credit_reg   <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The result register fills on the final step and empties when taken.
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= charge_now ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        state_reg <= ST_AIR;
                    end
                end
                ST_AIR: begin
                    state_reg <= ST_DLT;
                end
                ST_DLT: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    credit_reg <= sum_sat[CREDIT_BITS-1:0];
                    last_reg   <= now_reg;
                    state_reg  <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        mode_reg  <= fin_mode;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= in_op;
            now_reg    <= in_now;
            ok_reg     <= in_ok;
            len_ok_reg <= len_ok;
            charge_reg <= charge_now;
            qneg_reg   <= num[dcac_pkg::NUM_W-1];
            dzero_reg  <= (den == '0);
        end
        if (mul_done) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_AIR) begin
            air_reg <= dcac_pkg::AIR_W'(sym_pos) << sf_reg;
            ten_reg <= dcac_pkg::TEN_W'({elapsed, 3'b000})
                     + dcac_pkg::TEN_W'({elapsed, 1'b0});
        end
        if (state_reg == ST_DLT) begin
            delta_reg <= $signed(dcac_pkg::DELTA_W'(ten_reg))
                       - $signed(dcac_pkg::DELTA_W'(air_reg));
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_tdata_reg <= {3'b000, fin_too_long, fin_neg, fin_air,
                            cr_shown[dcac_pkg::OUT_CR_W-1:0], fin_mode, fin_granted};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration port: writes land on the access cycle; reads are direct.
    logic                              cfg_we;
    logic [dcac_pkg::REG_IX_W-1:0]     cfg_ix;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign cfg_ix = paddr[dcac_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg  <= dcac_pkg::SF_RESET;
            pre_reg <= dcac_pkg::PREAMBLE_RESET;
            cr_reg  <= dcac_pkg::CR_RESET;
            crc_reg <= dcac_pkg::CRC_RESET;
            imp_reg <= dcac_pkg::IMPLICIT_RESET;
        end else if (cfg_we) begin
            case (cfg_ix)
                dcac_pkg::REG_SF:       sf_reg  <= pwdata[3:0];
                dcac_pkg::REG_PREAMBLE: pre_reg <= pwdata[15:0];
                dcac_pkg::REG_CR:       cr_reg  <= pwdata[3:0];
                dcac_pkg::REG_CRC:      crc_reg <= pwdata[0];
                dcac_pkg::REG_IMPLICIT: imp_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_ix)
            dcac_pkg::REG_SF:       prdata = {28'b0, sf_reg};
            dcac_pkg::REG_PREAMBLE: prdata = {16'b0, pre_reg};
            dcac_pkg::REG_CR:       prdata = {28'b0, cr_reg};
            dcac_pkg::REG_CRC:      prdata = {31'b0, crc_reg};
            dcac_pkg::REG_IMPLICIT: prdata = {31'b0, imp_reg};
            default:                prdata = '0;
        endcase
    end

endmodule : duty_cycle_airtime_credit_top

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the airtime credit block
// Drives init, send and promote items through the stream input, writes the
// configuration over the register port, and checks every result against an
// in-bench prediction or a typed verdict of mode, credit and time on air.
// ----------------------------------------------------------------------------

module testbench;

    // The block is built with its default payload limit.
    localparam int PAYLOAD_LIMIT = 256;
    localparam int DIRECTED_ROWS = 22;
    localparam int PHASE_COUNT   = 6;
    // Receiver hold-off used to back the block up into a stalled input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Tail window after the last drain, long enough to cover any straggler.
    localparam int TAIL_CYCLES = 60;

    // One result item, unpacked from m_tdata.
    typedef struct packed {
        logic            granted;
        dcac_pkg::mode_t mode;
        logic [39:0]     credit_us;
        logic [31:0]     airtime_us;
        logic            credit_negative;
        logic            too_long;
    } verdict_t;

    // One row of the directed table. Rows with a typed verdict are checked
    // against that value; the others against the prediction.
    typedef struct packed {
        dcac_pkg::op_t op;
        logic [31:0]   now_ms;
        logic [15:0]   length;
        logic          radio_ok;
        logic          typed;
        verdict_t      want;
    } stim_row_t;

    // Traffic shapes of the random part.
    typedef enum logic [1:0] {
        FLOW_MIXED, // all operations, time moving forward in small steps
        FLOW_DRAIN, // mostly sends with no time elapsed, to sink the credit
        FLOW_FILL   // mostly sends with the longest elapsed time, to raise it
    } traffic_t;

    typedef struct packed {
        logic [3:0]  sf;
        logic [15:0] preamble;
        logic [3:0]  cr;
        logic        crc;
        logic        implicit_hdr;
        traffic_t    traffic;
        int          items;
        logic        calm;       // no idling on either side during the phase
        logic        hold_off;   // receiver holds off at the start of the phase
        int          pause_at;   // sender waits for all results before this item
    } phase_t;

    localparam verdict_t NO_VERDICT = '0;

    // Directed items. The first eight start from reset, so their results are
    // known outright: ignored code, refused payloads, init and promote from
    // offline and end node. The rest cover payload extremes, the clock wrap,
    // no elapsed time, and the gateway path.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{dcac_pkg::OP_NONE,    32'h0000_0000, 16'd0,     1'b0, 1'b1,
          '{1'b0, dcac_pkg::MODE_OFFLINE,  40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_PROMOTE, 32'h0000_0000, 16'd0,     1'b0, 1'b1,
          '{1'b0, dcac_pkg::MODE_OFFLINE,  40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_INIT,    32'h0000_0000, 16'd0,     1'b0, 1'b1,
          '{1'b0, dcac_pkg::MODE_OFFLINE,  40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_SEND,    32'h0000_0005, 16'd257,   1'b0, 1'b1,
          '{1'b0, dcac_pkg::MODE_OFFLINE,  40'd0, 32'd0, 1'b0, 1'b1}},
        '{dcac_pkg::OP_SEND,    32'hFFFF_FFFF, 16'hFFFF,  1'b1, 1'b1,
          '{1'b0, dcac_pkg::MODE_OFFLINE,  40'd0, 32'd0, 1'b0, 1'b1}},
        '{dcac_pkg::OP_INIT,    32'h0000_0000, 16'd0,     1'b1, 1'b1,
          '{1'b1, dcac_pkg::MODE_END_NODE, 40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_PROMOTE, 32'h0000_0000, 16'd0,     1'b1, 1'b1,
          '{1'b0, dcac_pkg::MODE_END_NODE, 40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_NONE,    32'hFFFF_FFFF, 16'hFFFF,  1'b1, 1'b1,
          '{1'b0, dcac_pkg::MODE_END_NODE, 40'd0, 32'd0, 1'b0, 1'b0}},
        '{dcac_pkg::OP_SEND,    32'h0000_0000, 16'd0,     1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'h0000_03E8, 16'd256,   1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'hFFFF_FFFF, 16'd1,     1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'h7FFF_FFFF, 16'd128,   1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'h7FFF_FFFF, 16'd256,   1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_INIT,    32'h0000_0000, 16'd0,     1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_PROMOTE, 32'h0000_0000, 16'd0,     1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_PROMOTE, 32'h0000_0000, 16'd0,     1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_PROMOTE, 32'h1234_5678, 16'd0,     1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_NONE,    32'h0000_0000, 16'd0,     1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'h0000_0000, 16'd257,   1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_INIT,    32'h0000_0000, 16'd0,     1'b1, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_SEND,    32'hAAAA_5555, 16'd200,   1'b0, 1'b0, NO_VERDICT},
        '{dcac_pkg::OP_PROMOTE, 32'h5555_AAAA, 16'h5555,  1'b1, 1'b0, NO_VERDICT}
    };

    // Register settings per phase. They include the spec corners and the
    // field extremes: a zero spreading factor has no divisor, and the largest
    // settings give a time on air beyond 32 bits.
    localparam phase_t PHASES [PHASE_COUNT] = '{
        '{4'd6,  16'd6,     4'd5,  1'b0, 1'b0, FLOW_MIXED, 60,  1'b0, 1'b1, -1},
        '{4'd12, 16'd8,     4'd8,  1'b1, 1'b1, FLOW_MIXED, 60,  1'b0, 1'b0, -1},
        '{4'd15, 16'd65535, 4'd15, 1'b1, 1'b0, FLOW_DRAIN, 150, 1'b1, 1'b0, -1},
        '{4'd0,  16'd0,     4'd0,  1'b0, 1'b1, FLOW_FILL,  60,  1'b0, 1'b0, -1},
        '{4'd7,  16'd12,    4'd6,  1'b1, 1'b0, FLOW_MIXED, 60,  1'b0, 1'b0, 30},
        '{4'd11, 16'd300,   4'd7,  1'b0, 1'b1, FLOW_MIXED, 40,  1'b0, 1'b0, -1}
    };

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [55:0]                 s_tdata;   // now_ms[31:0], payload_length[47:32],
                                            // radio_ok[48]
    logic [1:0]                  s_tuser;   // operation[1:0]
    logic                        m_tvalid;
    logic                        m_tready;
    logic [79:0]                 m_tdata;   // granted[0], mode[2:1], credit_us[42:3],
                                            // airtime_us[74:43], credit_negative[75],
                                            // too_long[76]
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dcac_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // Predicted copy of the configuration and of the block's state.
    logic [3:0]          cfg_sf;
    logic [15:0]         cfg_preamble;
    logic [3:0]          cfg_cr;
    logic                cfg_crc;
    logic                cfg_implicit;
    dcac_pkg::mode_t     radio_mode;
    longint              credit_balance;
    logic [31:0]         last_charge_ms;

    verdict_t            pending_results[$];
    int                  error_count;
    int                  results_seen;
    logic                calm;
    logic                hold_off_req;

    duty_cycle_airtime_credit_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    task automatic report_error(input string what);
        error_count++;
        $display("%0t ns result %0d: %s", $time, results_seen, what);
    endtask

    // Time on air in microseconds: symbol time 2^sf * 4 us times
    // (preamble + 4.25 + 8 + cr + q * cr) symbols, all scaled by four to stay
    // in integers. The quotient truncates toward zero; no divisor gives zero.
    function automatic longint airtime_of(input logic [15:0] length);
        longint sf;
        longint cr;
        longint num;
        longint den;
        longint q;
        longint symbols;
        sf  = longint'(cfg_sf);
        cr  = longint'(cfg_cr);
        num = 8 * longint'(length) - 4 * sf + 28 + 16 * longint'(cfg_crc)
              - 20 * longint'(cfg_implicit);
        den = 4 * sf;
        q   = (den != 0) ? num / den : 0;
        symbols = 4 * longint'(cfg_preamble) + 49 + 4 * cr + 4 * cr * q;
        if (symbols < 0) begin
            symbols = 0;
        end
        return symbols * (longint'(1) << sf);
    endfunction

    // Earn 10 us per elapsed ms (modulo the 32-bit clock), pay the time on
    // air, and saturate at 40 signed bits.
    function automatic longint charge_credit(input logic [31:0] now_ms,
                                             input logic [15:0] length,
                                             output logic negative);
        longint air;
        longint delta;
        longint hi;
        longint lo;
        logic [31:0] elapsed;
        air     = airtime_of(length);
        elapsed = now_ms - last_charge_ms;
        delta   = 10 * longint'(elapsed) - air;
        hi      = (longint'(1) << 39) - 1;
        lo      = -hi - 1;
        last_charge_ms = now_ms;
        if (delta > 0 && credit_balance > hi - delta) begin
            credit_balance = hi;
        end else if (delta < 0 && credit_balance < lo - delta) begin
            credit_balance = lo;
        end else begin
            credit_balance = credit_balance + delta;
        end
        negative = credit_balance < 0;
        return air;
    endfunction

    function automatic verdict_t predict_verdict(input dcac_pkg::op_t op,
                                                 input logic [31:0] now_ms,
                                                 input logic [15:0] length,
                                                 input logic radio_ok);
        verdict_t v;
        longint air;
        logic negative;
        v = '0;
        air = 0;
        negative = 1'b0;
        case (op)
            dcac_pkg::OP_INIT: begin
                radio_mode = radio_ok ? dcac_pkg::MODE_END_NODE : dcac_pkg::MODE_OFFLINE;
                v.granted = radio_ok;
            end
            dcac_pkg::OP_SEND: begin
                if (length <= PAYLOAD_LIMIT) begin
                    air = charge_credit(now_ms, length, negative);
                    v.granted = 1'b1;
                end else begin
                    v.too_long = 1'b1;
                end
            end
            dcac_pkg::OP_PROMOTE: begin
                case (radio_mode)
                    dcac_pkg::MODE_SUSPENDED: begin
                        // A suspended gateway pays for an empty packet first.
                        air = charge_credit(now_ms, 16'd0, negative);
                        if (credit_balance > 0) begin
                            radio_mode = dcac_pkg::MODE_GATEWAY;
                            v.granted = 1'b1;
                        end
                    end
                    dcac_pkg::MODE_GATEWAY: begin
                        if (credit_balance < dcac_pkg::GATE_FLOOR_US) begin
                            radio_mode = dcac_pkg::MODE_SUSPENDED;
                        end else begin
                            v.granted = 1'b1;
                        end
                    end
                    dcac_pkg::MODE_OFFLINE: begin
                        if (radio_ok) begin
                            radio_mode = dcac_pkg::MODE_GATEWAY;
                            v.granted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        v.mode            = radio_mode;
        v.credit_us       = credit_balance[39:0];
        v.airtime_us      = (air > 64'sd4294967295) ? 32'hFFFF_FFFF : air[31:0];
        v.credit_negative = negative;
        return v;
    endfunction

    // Random item for one traffic shape. Time is taken relative to the last
    // charge so that elapsed time is mostly small, zero, or the full wrap.
    function automatic void pick_item(input traffic_t traffic, output dcac_pkg::op_t op,
                                      output logic [31:0] now_ms,
                                      output logic [15:0] length,
                                      output logic radio_ok);
        int r;
        r = int'($urandom_range(0, 99));
        if (traffic == FLOW_MIXED) begin
            op = (r < 45) ? dcac_pkg::OP_SEND : (r < 70) ? dcac_pkg::OP_PROMOTE
               : (r < 92) ? dcac_pkg::OP_INIT : dcac_pkg::OP_NONE;
        end else begin
            op = (r < 62) ? dcac_pkg::OP_SEND : (r < 90) ? dcac_pkg::OP_PROMOTE
               : (r < 96) ? dcac_pkg::OP_INIT : dcac_pkg::OP_NONE;
        end

        r = int'($urandom_range(0, 99));
        case (traffic)
            FLOW_DRAIN: begin
                now_ms = (r < 90) ? last_charge_ms
                                  : last_charge_ms + $urandom_range(0, 1000);
            end
            FLOW_FILL: begin
                now_ms = (r < 85) ? last_charge_ms - 32'd1 : $urandom;
            end
            default: begin
                now_ms = (r < 80) ? last_charge_ms + $urandom_range(0, 20000)
                       : (r < 90) ? $urandom : last_charge_ms;
            end
        endcase

        r = int'($urandom_range(0, 99));
        if (traffic == FLOW_DRAIN && r < 70) begin
            length = 16'd256;
        end else if (r < 85) begin
            length = 16'($urandom_range(0, PAYLOAD_LIMIT));
        end else if (r < 95) begin
            length = 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
        end else begin
            length = 16'($urandom);
        end

        if (traffic == FLOW_MIXED) begin
            radio_ok = $urandom_range(0, 99) < 85;
        end else begin
            radio_ok = 1'($urandom_range(0, 1));
        end
    endfunction

    // Offer one item, wait for it to be taken, then record what must come back.
    task automatic offer_item(input dcac_pkg::op_t op, input logic [31:0] now_ms,
                              input logic [15:0] length, input logic radio_ok,
                              input logic typed, input verdict_t want);
        verdict_t predicted;
        while (!calm && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, radio_ok, length, now_ms};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_verdict(op, now_ms, length, radio_ok);
        if (typed) begin
            predicted = want;
        end
        pending_results = {pending_results, predicted};
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Register write followed by a read-back of the same register. The
    // prediction follows the write at its access edge.
    task automatic write_register(input logic [dcac_pkg::REG_IX_W-1:0] index,
                                  input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            dcac_pkg::REG_SF:       cfg_sf       = value[3:0];
            dcac_pkg::REG_PREAMBLE: cfg_preamble = value[15:0];
            dcac_pkg::REG_CR:       cfg_cr       = value[3:0];
            dcac_pkg::REG_CRC:      cfg_crc      = value[0];
            dcac_pkg::REG_IMPLICIT: cfg_implicit = value[0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value) begin
            report_error($sformatf("register %0d reads %0h, written %0h", index, prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_verdict(input logic [79:0] beat);
        verdict_t got;
        verdict_t want;
        got.granted         = beat[0];
        got.mode            = dcac_pkg::mode_t'(beat[2:1]);
        got.credit_us       = beat[42:3];
        got.airtime_us      = beat[74:43];
        got.credit_negative = beat[75];
        got.too_long        = beat[76];
        if (pending_results.size() == 0) begin
            report_error("result arrived with no item outstanding");
        end else begin
            want = pending_results.pop_front();
            if (got.granted !== want.granted) begin
                report_error($sformatf("granted %b, want %b", got.granted, want.granted));
            end
            if (got.mode !== want.mode) begin
                report_error($sformatf("mode %0d, want %0d", got.mode, want.mode));
            end
            if (got.credit_us !== want.credit_us) begin
                report_error($sformatf("credit_us %0d, want %0d",
                                       $signed(got.credit_us), $signed(want.credit_us)));
            end
            if (got.airtime_us !== want.airtime_us) begin
                report_error($sformatf("airtime_us %0d, want %0d",
                                       got.airtime_us, want.airtime_us));
            end
            if (got.credit_negative !== want.credit_negative) begin
                report_error($sformatf("credit_negative %b, want %b",
                                       got.credit_negative, want.credit_negative));
            end
            if (got.too_long !== want.too_long) begin
                report_error($sformatf("too_long %b, want %b", got.too_long, want.too_long));
            end
        end
        results_seen++;
    endtask

    // Result side. Results are taken at random, except while the stimulus asks
    // for a calm stretch, and once for a long hold-off that backs the block up
    // until it stops taking items.
    initial begin : result_sink
        int stall_cycles;
        logic held;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_verdict(m_tdata);
            end
            if (hold_off_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (stall_cycles = 0; stall_cycles < HOLD_OFF_CYCLES; stall_cycles++) begin
                    @(posedge aclk);
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    // Stimulus: reset, the directed table, then one random phase per register
    // setting. Registers change only once every result has come back.
    initial begin : stimulus
        int row;
        int ph;
        int n;
        dcac_pkg::op_t op;
        logic [31:0] now_ms;
        logic [15:0] length;
        logic radio_ok;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = dcac_pkg::OP_NONE;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        error_count  = 0;
        results_seen = 0;

        // Predicted state after reset.
        cfg_sf         = dcac_pkg::SF_RESET;
        cfg_preamble   = dcac_pkg::PREAMBLE_RESET;
        cfg_cr         = dcac_pkg::CR_RESET;
        cfg_crc        = dcac_pkg::CRC_RESET;
        cfg_implicit   = dcac_pkg::IMPLICIT_RESET;
        radio_mode     = dcac_pkg::MODE_OFFLINE;
        credit_balance = 0;
        last_charge_ms = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            offer_item(DIRECTED[row].op, DIRECTED[row].now_ms, DIRECTED[row].length,
                       DIRECTED[row].radio_ok, DIRECTED[row].typed, DIRECTED[row].want);
        end

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            write_register(dcac_pkg::REG_SF,       {28'd0, PHASES[ph].sf});
            write_register(dcac_pkg::REG_PREAMBLE, {16'd0, PHASES[ph].preamble});
            write_register(dcac_pkg::REG_CR,       {28'd0, PHASES[ph].cr});
            write_register(dcac_pkg::REG_CRC,      {31'd0, PHASES[ph].crc});
            write_register(dcac_pkg::REG_IMPLICIT, {31'd0, PHASES[ph].implicit_hdr});
            calm = PHASES[ph].calm;
            if (PHASES[ph].hold_off) begin
                hold_off_req = 1'b1;
            end
            for (n = 0; n < PHASES[ph].items; n++) begin
                // Mid-phase the sender goes quiet until the block has emptied.
                if (n == PHASES[ph].pause_at) begin
                    drain_results();
                end
                pick_item(PHASES[ph].traffic, op, now_ms, length, radio_ok);
                offer_item(op, now_ms, length, radio_ok, 1'b0, NO_VERDICT);
            end
        end

        calm = 1'b0;
        drain_results();
        // Anything arriving in this window has no item behind it.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_error("results still outstanding at the end");
        end
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin : watchdog
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
